// ===== rtl/msde_pkg.sv =====
`default_nettype none

package msde_pkg;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned REG_W   = 5;
    localparam logic [REG_W-1:0] LINK_REG = 5'd31;
    localparam int unsigned LUI_SHIFT  = 16;
    localparam int unsigned WORD_SHIFT = 2;

    localparam logic [5:0] OP_RTYPE = 6'h00;
    localparam logic [5:0] OP_J     = 6'h02;
    localparam logic [5:0] OP_JAL   = 6'h03;
    localparam logic [5:0] OP_BEQ   = 6'h04;
    localparam logic [5:0] OP_BNE   = 6'h05;
    localparam logic [5:0] OP_ADDI  = 6'h08;
    localparam logic [5:0] OP_ADDIU = 6'h09;
    localparam logic [5:0] OP_SLTI  = 6'h0A;
    localparam logic [5:0] OP_SLTIU = 6'h0B;
    localparam logic [5:0] OP_ANDI  = 6'h0C;
    localparam logic [5:0] OP_ORI   = 6'h0D;
    localparam logic [5:0] OP_LUI   = 6'h0F;
    localparam logic [5:0] OP_LW    = 6'h23;
    localparam logic [5:0] OP_SW    = 6'h2B;

    localparam logic [5:0] FN_SLL     = 6'h00;
    localparam logic [5:0] FN_SRL     = 6'h02;
    localparam logic [5:0] FN_JR      = 6'h08;
    localparam logic [5:0] FN_SYSCALL = 6'h0C;
    localparam logic [5:0] FN_ADD     = 6'h20;
    localparam logic [5:0] FN_ADDU    = 6'h21;
    localparam logic [5:0] FN_SUB     = 6'h22;
    localparam logic [5:0] FN_SUBU    = 6'h23;
    localparam logic [5:0] FN_AND     = 6'h24;
    localparam logic [5:0] FN_OR      = 6'h25;
    localparam logic [5:0] FN_NOR     = 6'h27;
    localparam logic [5:0] FN_SLT     = 6'h2A;
    localparam logic [5:0] FN_SLTU    = 6'h2B;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_SYSCALL  = 2'd1,
        STAT_BAD_OP   = 2'd2,
        STAT_BAD_FUNC = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        MEM_NONE  = 2'd0,
        MEM_LOAD  = 2'd1,
        MEM_STORE = 2'd2
    } mem_op_t;

    typedef struct packed {
        logic [WORD_W-1:0] instruction;
        logic [WORD_W-1:0] source_value;
        logic [WORD_W-1:0] target_value;
        logic [WORD_W-1:0] next_pc;
    } inst_t;

    typedef struct packed {
        status_t           status;
        logic [WORD_W-1:0] alu_result;
        logic [WORD_W-1:0] store_data;
        logic [REG_W-1:0]  dest_reg;
        logic              wb_enable;
        mem_op_t           mem_op;
        logic              redirect;
        logic [WORD_W-1:0] target_pc;
    } res_t;

endpackage

`default_nettype wire

// ===== rtl/mips_subset_decode_execute.sv =====
// MIPS32 integer subset decode and execute.
//
// Input channel: inst_valid / inst_stall / inst carry one instruction word with
// its rs and rt register values and the incremented PC. Output channel:
// res_valid / res_stall / res carry the ALU value, store data, write-back
// destination, memory operation, PC redirect and status. A transaction moves
// at a rising edge with valid high and stall low.
//
// Three register stages: capture, decode, execute/result. A result shows on
// res once its instruction has passed the capture and decode registers into
// the result register; while inst_stall is low, one instruction can be taken
// every cycle. The result register drives res directly.
//
// Reset clears the stage valid bits; the payload registers are not reset.
// When res_stall is high the held result stays put, earlier stages keep
// filling their empty slots, and inst_stall rises only once all three stages
// hold work. No transaction is dropped or repeated.
`default_nettype none

module mips_subset_decode_execute (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           inst_valid,
    output logic                inst_stall,
    input  wire msde_pkg::inst_t inst,
    output logic                res_valid,
    input  wire logic           res_stall,
    output msde_pkg::res_t      res
);
    import msde_pkg::*;

    typedef enum logic [3:0] {
        ALU_ZERO,
        ALU_ADD,
        ALU_SUB,
        ALU_AND,
        ALU_OR,
        ALU_NOR,
        ALU_SLT,
        ALU_SLTU,
        ALU_SLL,
        ALU_SRL,
        ALU_PASS_B
    } alu_op_t;

    typedef struct packed {
        alu_op_t           alu_op;
        logic [WORD_W-1:0] opa;
        logic [WORD_W-1:0] opb;
        logic [4:0]        shamt;
        logic              is_beq;
        logic              is_bne;
        logic              jump;
        logic [WORD_W-1:0] target;
        logic [WORD_W-1:0] offset;
        status_t           status;
        logic [REG_W-1:0]  dest;
        logic              wr;
        mem_op_t           mem_op;
        logic [WORD_W-1:0] sdata;
    } dec_t;

    // Stage valid bits and payloads
    logic  a_valid_reg, b_valid_reg, c_valid_reg;
    logic  a_valid_next, b_valid_next, c_valid_next;
    inst_t a_reg;
    dec_t  b_reg, b_next;
    res_t  c_reg, c_next;

    logic a_ready, b_ready, c_ready;

    assign c_ready    = !c_valid_reg || !res_stall;
    assign b_ready    = !b_valid_reg || c_ready;
    assign a_ready    = !a_valid_reg || b_ready;
    assign inst_stall = !a_ready;
    assign res_valid  = c_valid_reg;
    assign res        = c_reg;

    assign a_valid_next = a_ready ? inst_valid  : a_valid_reg;
    assign b_valid_next = b_ready ? a_valid_reg : b_valid_reg;
    assign c_valid_next = c_ready ? b_valid_reg : c_valid_reg;

    // Decode
    logic [5:0]        d_op, d_fn;
    logic [REG_W-1:0]  d_rt, d_rd;
    logic [15:0]       d_imm;
    logic [WORD_W-1:0] d_simm, d_zimm;

    assign d_op   = a_reg.instruction[31:26];
    assign d_fn   = a_reg.instruction[5:0];
    assign d_rt   = a_reg.instruction[20:16];
    assign d_rd   = a_reg.instruction[15:11];
    assign d_imm  = a_reg.instruction[15:0];
    assign d_simm = {{(WORD_W-16){d_imm[15]}}, d_imm};
    assign d_zimm = {{(WORD_W-16){1'b0}}, d_imm};

    always_comb
    begin
        dec_t d;
        d        = '0;
        d.alu_op = ALU_ZERO;
        d.status = STAT_OK;
        d.mem_op = MEM_NONE;
        d.opa    = a_reg.source_value;
        d.opb    = a_reg.target_value;
        d.shamt  = a_reg.instruction[10:6];
        unique case (d_op)
            OP_RTYPE:
            begin
                d.dest = d_rd;
                d.wr   = 1'b1;
                unique case (d_fn)
                    FN_SLL:            d.alu_op = ALU_SLL;
                    FN_SRL:            d.alu_op = ALU_SRL;
                    FN_ADD, FN_ADDU:   d.alu_op = ALU_ADD;
                    FN_SUB, FN_SUBU:   d.alu_op = ALU_SUB;
                    FN_AND:            d.alu_op = ALU_AND;
                    FN_OR:             d.alu_op = ALU_OR;
                    FN_NOR:            d.alu_op = ALU_NOR;
                    FN_SLT:            d.alu_op = ALU_SLT;
                    FN_SLTU:           d.alu_op = ALU_SLTU;
                    FN_JR:
                    begin
                        d.dest   = '0;
                        d.wr     = 1'b0;
                        d.jump   = 1'b1;
                        d.target = a_reg.source_value;
                    end
                    FN_SYSCALL:
                    begin
                        d.dest   = '0;
                        d.wr     = 1'b0;
                        d.status = STAT_SYSCALL;
                    end
                    default:
                    begin
                        d.dest   = '0;
                        d.wr     = 1'b0;
                        d.status = STAT_BAD_FUNC;
                    end
                endcase
            end
            OP_J, OP_JAL:
            begin
                d.jump   = 1'b1;
                d.target = {a_reg.next_pc[WORD_W-1:WORD_W-4],
                            a_reg.instruction[25:0], {WORD_SHIFT{1'b0}}};
                if (d_op == OP_JAL)
                begin
                    d.alu_op = ALU_PASS_B;
                    d.opb    = a_reg.next_pc;
                    d.dest   = LINK_REG;
                    d.wr     = 1'b1;
                end
            end
            OP_BEQ, OP_BNE:
            begin
                d.alu_op = ALU_SUB;
                d.is_beq = (d_op == OP_BEQ);
                d.is_bne = (d_op == OP_BNE);
                d.target = a_reg.next_pc;
                d.offset = d_simm << WORD_SHIFT;
            end
            OP_ADDI, OP_ADDIU:
            begin
                d.alu_op = ALU_ADD;
                d.opb    = d_simm;
                d.dest   = d_rt;
                d.wr     = 1'b1;
            end
            OP_SLTI:
            begin
                d.alu_op = ALU_SLT;
                d.opb    = d_simm;
                d.dest   = d_rt;
                d.wr     = 1'b1;
            end
            OP_SLTIU:
            begin
                d.alu_op = ALU_SLTU;
                d.opb    = d_simm;
                d.dest   = d_rt;
                d.wr     = 1'b1;
            end
            OP_ANDI:
            begin
                d.alu_op = ALU_AND;
                d.opb    = d_zimm;
                d.dest   = d_rt;
                d.wr     = 1'b1;
            end
            OP_ORI:
            begin
                d.alu_op = ALU_OR;
                d.opb    = d_zimm;
                d.dest   = d_rt;
                d.wr     = 1'b1;
            end
            OP_LUI:
            begin
                d.alu_op = ALU_PASS_B;
                d.opb    = d_zimm << LUI_SHIFT;
                d.dest   = d_rt;
                d.wr     = 1'b1;
            end
            OP_LW:
            begin
                d.alu_op = ALU_ADD;
                d.opb    = d_simm;
                d.dest   = d_rt;
                d.wr     = 1'b1;
                d.mem_op = MEM_LOAD;
            end
            OP_SW:
            begin
                d.alu_op = ALU_ADD;
                d.opb    = d_simm;
                d.mem_op = MEM_STORE;
                d.sdata  = a_reg.target_value;
            end
            default:
            begin
                d.status = STAT_BAD_OP;
            end
        endcase
        // register 0 is never written, but the index still shows
        if (d.dest == '0)
        begin
            d.wr = 1'b0;
        end
        b_next = d;
    end

    // Execute
    logic [WORD_W-1:0] x_sum, x_diff, x_alu, x_btarget;
    logic              x_zero, x_taken;

    assign x_sum     = b_reg.opa + b_reg.opb;
    assign x_diff    = b_reg.opa - b_reg.opb;
    assign x_zero    = (x_diff == '0);
    assign x_btarget = b_reg.target + b_reg.offset;
    assign x_taken   = (b_reg.is_beq && x_zero) || (b_reg.is_bne && !x_zero);

    always_comb
    begin
        unique case (b_reg.alu_op)
            ALU_ZERO:   x_alu = '0;
            ALU_ADD:    x_alu = x_sum;
            ALU_SUB:    x_alu = x_diff;
            ALU_AND:    x_alu = b_reg.opa & b_reg.opb;
            ALU_OR:     x_alu = b_reg.opa | b_reg.opb;
            ALU_NOR:    x_alu = ~(b_reg.opa | b_reg.opb);
            ALU_SLT:    x_alu = {{(WORD_W-1){1'b0}},
                                 ($signed(b_reg.opa) < $signed(b_reg.opb))};
            ALU_SLTU:   x_alu = {{(WORD_W-1){1'b0}}, (b_reg.opa < b_reg.opb)};
            ALU_SLL:    x_alu = b_reg.opb << b_reg.shamt;
            ALU_SRL:    x_alu = b_reg.opb >> b_reg.shamt;
            ALU_PASS_B: x_alu = b_reg.opb;
            default:    x_alu = '0;
        endcase
    end

    always_comb
    begin
        c_next            = '0;
        c_next.status     = b_reg.status;
        c_next.alu_result = x_alu;
        c_next.store_data = b_reg.sdata;
        c_next.dest_reg   = b_reg.dest;
        c_next.wb_enable  = b_reg.wr;
        c_next.mem_op     = b_reg.mem_op;
        priority if (b_reg.jump)
        begin
            c_next.redirect  = 1'b1;
            c_next.target_pc = b_reg.target;
        end
        else if (x_taken)
        begin
            c_next.redirect  = 1'b1;
            c_next.target_pc = x_btarget;
        end
        else
        begin
            c_next.redirect  = 1'b0;
            c_next.target_pc = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
            c_valid_reg <= c_valid_next;
        end
    end

    // Payloads advance only where the next stage has room
    always_ff @(posedge clk)
    begin
        if (a_ready)
        begin
            a_reg <= inst;
        end
        if (b_ready)
        begin
            b_reg <= b_next;
        end
        if (c_ready)
        begin
            c_reg <= c_next;
        end
    end

    a_no_zero_write: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !(res.wb_enable && res.dest_reg == '0))
        else $error("write-back to register zero");

    a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.status != STAT_OK |->
            res.alu_result == '0 && !res.wb_enable && !res.redirect &&
            res.mem_op == MEM_NONE && res.target_pc == '0)
        else $error("exceptional status with live result fields");

    a_target_idle: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res.redirect |-> res.target_pc == '0)
        else $error("target without redirect");

    a_store_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.mem_op == MEM_STORE |-> !res.wb_enable)
        else $error("store also writes a register");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        inst_stall |-> res_valid && res_stall && a_valid_reg && b_valid_reg)
        else $error("input stalled with room in the pipeline");

endmodule

`default_nettype wire

// ===== dv/mips_subset_decode_execute_tb.sv =====
`timescale 1ns / 100ps

module mips_subset_decode_execute_tb;

    import msde_pkg::*;

    localparam int unsigned RANDOM_ITEMS = 1500;
    localparam int unsigned CYCLE_LIMIT  = 1_000_000;
    localparam int unsigned SETTLE_CYCLES = 12;
    localparam int unsigned REPORT_LIMIT  = 10;

    localparam logic [5:0] OP_BOGUS = 6'h3F;
    localparam logic [5:0] FN_BOGUS = 6'h3F;

    typedef struct {
        logic [WORD_W-1:0] word;
        res_t              outcome;
    } pending_outcome_t;

    logic   clk;
    logic   rst_n      = 1'b0;
    logic   inst_valid = 1'b0;
    logic   inst_stall;
    inst_t  inst       = '0;
    logic   res_valid;
    logic   res_stall  = 1'b0;
    res_t   res;

    inst_t            inst_backlog[$];
    pending_outcome_t outcomes_due[$];

    int unsigned cycle_count   = 0;
    int unsigned idle_left     = 0;
    int unsigned stall_left    = 0;
    int unsigned calm_in       = 0;
    int unsigned calm_out      = 0;
    int unsigned issued        = 0;
    int unsigned directed_cnt  = 0;
    int unsigned checked       = 0;
    int unsigned error_count   = 0;
    int unsigned redirects     = 0;
    int unsigned writebacks    = 0;
    int unsigned mem_accesses  = 0;
    int unsigned traps         = 0;

    mips_subset_decode_execute uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .inst_valid (inst_valid),
        .inst_stall (inst_stall),
        .inst       (inst),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res        (res)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Decode and execute one instruction the way the core should.
    function automatic res_t predict_result(inst_t t);
        res_t              r;
        logic [5:0]        op;
        logic [5:0]        fn;
        logic [4:0]        rt;
        logic [4:0]        rd;
        logic [4:0]        sh;
        logic [WORD_W-1:0] imm_z;
        logic [WORD_W-1:0] imm_s;
        logic [WORD_W-1:0] diff;
        r      = '0;
        op     = t.instruction[31:26];
        rt     = t.instruction[20:16];
        rd     = t.instruction[15:11];
        sh     = t.instruction[10:6];
        fn     = t.instruction[5:0];
        imm_z  = {16'b0, t.instruction[15:0]};
        imm_s  = {{16{t.instruction[15]}}, t.instruction[15:0]};
        r.status = STAT_OK;
        r.mem_op = MEM_NONE;
        case (op)
            OP_RTYPE:
            begin
                r.dest_reg  = rd;
                r.wb_enable = 1'b1;
                case (fn)
                    FN_SLL:  r.alu_result = t.target_value << sh;
                    FN_SRL:  r.alu_result = t.target_value >> sh;
                    FN_JR:
                    begin
                        r.dest_reg  = '0;
                        r.wb_enable = 1'b0;
                        r.redirect  = 1'b1;
                        r.target_pc = t.source_value;
                    end
                    FN_SYSCALL:
                    begin
                        r.dest_reg  = '0;
                        r.wb_enable = 1'b0;
                        r.status    = STAT_SYSCALL;
                    end
                    FN_ADD, FN_ADDU: r.alu_result = t.source_value + t.target_value;
                    FN_SUB, FN_SUBU: r.alu_result = t.source_value - t.target_value;
                    FN_AND:  r.alu_result = t.source_value & t.target_value;
                    FN_OR:   r.alu_result = t.source_value | t.target_value;
                    FN_NOR:  r.alu_result = ~(t.source_value | t.target_value);
                    FN_SLT:  r.alu_result = {31'b0,
                                 $signed(t.source_value) < $signed(t.target_value)};
                    FN_SLTU: r.alu_result = {31'b0, t.source_value < t.target_value};
                    default:
                    begin
                        r.dest_reg  = '0;
                        r.wb_enable = 1'b0;
                        r.status    = STAT_BAD_FUNC;
                    end
                endcase
            end
            OP_J, OP_JAL:
            begin
                r.redirect  = 1'b1;
                r.target_pc = (32'(t.instruction[25:0]) << WORD_SHIFT)
                            | (t.next_pc & 32'hF000_0000);
                if (op == OP_JAL)
                begin
                    r.alu_result = t.next_pc;
                    r.dest_reg   = LINK_REG;
                    r.wb_enable  = 1'b1;
                end
            end
            OP_BEQ, OP_BNE:
            begin
                diff         = t.source_value - t.target_value;
                r.alu_result = diff;
                r.redirect   = (op == OP_BEQ) ? (diff == '0) : (diff != '0);
                if (r.redirect)
                    r.target_pc = t.next_pc + (imm_s << WORD_SHIFT);
            end
            OP_ADDI, OP_ADDIU:
            begin
                r.alu_result = t.source_value + imm_s;
                r.dest_reg   = rt;
                r.wb_enable  = 1'b1;
            end
            OP_SLTI:
            begin
                r.alu_result = {31'b0, $signed(t.source_value) < $signed(imm_s)};
                r.dest_reg   = rt;
                r.wb_enable  = 1'b1;
            end
            OP_SLTIU:
            begin
                r.alu_result = {31'b0, t.source_value < imm_s};
                r.dest_reg   = rt;
                r.wb_enable  = 1'b1;
            end
            OP_ANDI:
            begin
                r.alu_result = t.source_value & imm_z;
                r.dest_reg   = rt;
                r.wb_enable  = 1'b1;
            end
            OP_ORI:
            begin
                r.alu_result = t.source_value | imm_z;
                r.dest_reg   = rt;
                r.wb_enable  = 1'b1;
            end
            OP_LUI:
            begin
                r.alu_result = imm_z << LUI_SHIFT;
                r.dest_reg   = rt;
                r.wb_enable  = 1'b1;
            end
            OP_LW:
            begin
                r.alu_result = t.source_value + imm_s;
                r.dest_reg   = rt;
                r.wb_enable  = 1'b1;
                r.mem_op     = MEM_LOAD;
            end
            OP_SW:
            begin
                r.alu_result = t.source_value + imm_s;
                r.store_data = t.target_value;
                r.mem_op     = MEM_STORE;
            end
            default: r.status = STAT_BAD_OP;
        endcase
        // register 0 is never written, but the index still shows
        if (r.dest_reg == '0)
            r.wb_enable = 1'b0;
        return r;
    endfunction

    function automatic logic [31:0] r_word(int unsigned rs, int unsigned rt, int unsigned rd,
                                           int unsigned sh, logic [5:0] fn);
        return {OP_RTYPE, 5'(rs), 5'(rt), 5'(rd), 5'(sh), fn};
    endfunction

    function automatic logic [31:0] i_word(logic [5:0] op, int unsigned rs, int unsigned rt,
                                           logic [15:0] imm);
        return {op, 5'(rs), 5'(rt), imm};
    endfunction

    function automatic logic [31:0] j_word(logic [5:0] op, logic [25:0] index);
        return {op, index};
    endfunction

    task automatic queue_inst(logic [31:0] word, logic [31:0] rs_val, logic [31:0] rt_val,
                              logic [31:0] pc_plus4);
        inst_t t;
        t.instruction  = word;
        t.source_value = rs_val;
        t.target_value = rt_val;
        t.next_pc      = pc_plus4;
        inst_backlog.push_back(t);
    endtask

    function automatic logic [31:0] operand_value();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return 32'h8000_0000;
            3:       return 32'h7FFF_FFFF;
            4:       return 32'($urandom_range(0, 31));
            5:       return 32'(0) - 32'($urandom_range(1, 32));
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [15:0] immediate_value();
        case ($urandom_range(0, 7))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'hFFFF;
            3:       return 16'h0000;
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic logic [5:0] pick_funct();
        case ($urandom_range(0, 12))
            0:       return FN_SLL;
            1:       return FN_SRL;
            2:       return FN_JR;
            3:       return FN_SYSCALL;
            4:       return FN_ADD;
            5:       return FN_ADDU;
            6:       return FN_SUB;
            7:       return FN_SUBU;
            8:       return FN_AND;
            9:       return FN_OR;
            10:      return FN_NOR;
            11:      return FN_SLT;
            default: return FN_SLTU;
        endcase
    endfunction

    function automatic logic [5:0] pick_opcode();
        case ($urandom_range(0, 12))
            0:       return OP_J;
            1:       return OP_JAL;
            2:       return OP_BEQ;
            3:       return OP_BNE;
            4:       return OP_ADDI;
            5:       return OP_ADDIU;
            6:       return OP_SLTI;
            7:       return OP_SLTIU;
            8:       return OP_ANDI;
            9:       return OP_ORI;
            10:      return OP_LUI;
            11:      return OP_LW;
            default: return OP_SW;
        endcase
    endfunction

    // Mostly short pauses, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 88)
            return $urandom_range(1, 3);
        else if (roll < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    task automatic build_directed();
        // wrap without trap, signed versus unsigned compares
        queue_inst(r_word(1, 2, 3, 0, FN_ADD), 32'h7FFF_FFFF, 32'h1, 32'h0000_1004);
        queue_inst(r_word(4, 5, 6, 0, FN_ADDU), '1, '1, 32'h0000_1008);
        queue_inst(r_word(7, 8, 9, 0, FN_SUB), '0, 32'h1, 32'h0000_100C);
        queue_inst(r_word(10, 11, 12, 0, FN_SUBU), 32'h8000_0000, 32'h7FFF_FFFF, '0);
        queue_inst(r_word(1, 2, 31, 0, FN_AND), 32'hFFFF_0000, 32'h0F0F_0F0F, '1);
        queue_inst(r_word(1, 2, 30, 0, FN_OR), 32'hA5A5_0000, 32'h0000_5A5A, 32'h4);
        queue_inst(r_word(1, 2, 29, 0, FN_NOR), '0, '0, 32'h8);
        queue_inst(r_word(3, 4, 5, 0, FN_SLT), 32'h8000_0000, 32'h1, 32'h10);
        queue_inst(r_word(3, 4, 5, 0, FN_SLTU), 32'h8000_0000, 32'h1, 32'h14);
        // shifts ignore rs; non-shifts ignore shamt
        queue_inst(r_word(31, 4, 5, 31, FN_SLL), 32'h1234_5678, '1, 32'h18);
        queue_inst(r_word(31, 4, 5, 31, FN_SRL), '0, '1, 32'h1C);
        queue_inst(r_word(1, 2, 0, 17, FN_ADD), 32'h5, 32'h6, 32'h20);
        queue_inst(r_word(9, 0, 0, 0, FN_JR), 32'hDEAD_BEEC, '1, 32'h24);
        queue_inst({OP_RTYPE, 20'hFFFFF, FN_SYSCALL}, '1, '1, '1);
        queue_inst(r_word(1, 2, 3, 0, FN_BOGUS), '1, '1, '1);
        queue_inst({OP_BOGUS, 26'h3FF_FFFF}, '1, '1, '1);
        queue_inst(i_word(OP_BEQ, 1, 2, 16'h8000), 32'h55, 32'h55, 32'h0002_0000);
        queue_inst(i_word(OP_BEQ, 1, 2, 16'h0004), 32'h55, 32'h56, 32'h0002_0000);
        queue_inst(i_word(OP_BNE, 1, 2, 16'h7FFF), '0, '1, 32'hFFFF_FFFC);
        queue_inst(i_word(OP_BNE, 1, 2, 16'hFFFF), '1, '1, 32'h100);
        queue_inst(j_word(OP_J, 26'h3FF_FFFF), '1, '1, 32'hFFFF_FFFC);
        queue_inst(j_word(OP_JAL, 26'h000_0000), '0, '0, 32'hF000_0000);
        queue_inst(i_word(OP_ADDI, 1, 0, 16'h8000), 32'h7FFF_FFFF, '0, 32'h30);
        queue_inst(i_word(OP_ADDIU, 1, 2, 16'hFFFF), '0, '0, 32'h34);
        queue_inst(i_word(OP_SLTI, 1, 2, 16'hFFFF), 32'h8000_0000, '0, 32'h38);
        queue_inst(i_word(OP_SLTIU, 1, 2, 16'hFFFF), 32'hFFFF_FFFE, '0, 32'h3C);
        queue_inst(i_word(OP_ANDI, 1, 2, 16'hFFFF), '1, '0, 32'h40);
        queue_inst(i_word(OP_ORI, 1, 2, 16'h8000), '0, '0, 32'h44);
        queue_inst(i_word(OP_LUI, 31, 2, 16'hFFFF), '1, '1, 32'h48);
        queue_inst(i_word(OP_LW, 1, 2, 16'h8000), 32'h0000_1000, '0, 32'h4C);
        queue_inst(i_word(OP_SW, 1, 2, 16'h7FFF), '1, 32'hCAFE_F00D, 32'h50);
        directed_cnt = inst_backlog.size();
    endtask

    task automatic build_random();
        logic [31:0] word;
        logic [31:0] rs_val;
        logic [31:0] rt_val;
        int unsigned roll;
        repeat (RANDOM_ITEMS)
        begin
            word = $urandom();
            roll = $urandom_range(0, 99);
            if (roll < 45)
            begin
                word[31:26] = OP_RTYPE;
                word[5:0]   = pick_funct();
            end
            else if (roll < 85)
            begin
                word[31:26] = pick_opcode();
                if (word[31:26] != OP_J && word[31:26] != OP_JAL)
                    word[15:0] = immediate_value();
            end
            else if (roll < 93)
                word[31:26] = OP_RTYPE;
            rs_val = operand_value();
            rt_val = ($urandom_range(0, 3) == 0) ? rs_val : operand_value();
            queue_inst(word, rs_val, rt_val, $urandom());
        end
    endtask

    // Instruction driver: hold the payload while stalled, advance when taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inst_valid <= 1'b0;
            idle_left  <= 0;
        end
        else if (!inst_valid || !inst_stall)
        begin
            if (inst_valid)
            begin
                outcomes_due.push_back('{inst.instruction, predict_result(inst)});
                issued <= issued + 1;
            end
            if (idle_left > 0 || inst_backlog.size() == 0)
            begin
                inst_valid <= 1'b0;
                if (idle_left > 0)
                    idle_left <= idle_left - 1;
            end
            else
            begin
                inst       <= inst_backlog.pop_front();
                inst_valid <= 1'b1;
                if (calm_in > 0)
                begin
                    calm_in = calm_in - 1;
                    idle_left <= 0;
                end
                else
                begin
                    if ($urandom_range(0, 99) == 0)
                        calm_in = $urandom_range(30, 120);
                    idle_left <= pick_gap();
                end
            end
        end
    end

    // Result monitor with random backpressure.
    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        pending_outcome_t due;
        if (!rst_n)
        begin
            res_stall  <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (res_valid && !res_stall)
            begin
                if (outcomes_due.size() == 0)
                begin
                    error_count = error_count + 1;
                    if (error_count <= REPORT_LIMIT)
                        $display("unexpected result at cycle %0d: alu=%h", cycle_count,
                                 res.alu_result);
                end
                else
                begin
                    due = outcomes_due.pop_front();
                    checked = checked + 1;
                    if (due.outcome.redirect)
                        redirects = redirects + 1;
                    if (due.outcome.wb_enable)
                        writebacks = writebacks + 1;
                    if (due.outcome.mem_op != MEM_NONE)
                        mem_accesses = mem_accesses + 1;
                    if (due.outcome.status != STAT_OK)
                        traps = traps + 1;
                    if (res.status     !== due.outcome.status     ||
                        res.alu_result !== due.outcome.alu_result ||
                        res.store_data !== due.outcome.store_data ||
                        res.dest_reg   !== due.outcome.dest_reg   ||
                        res.wb_enable  !== due.outcome.wb_enable  ||
                        res.mem_op     !== due.outcome.mem_op     ||
                        res.redirect   !== due.outcome.redirect   ||
                        res.target_pc  !== due.outcome.target_pc)
                    begin
                        error_count = error_count + 1;
                        if (error_count <= REPORT_LIMIT)
                        begin
                            $display("mismatch on instruction %h", due.word);
                            $display("  expected st=%0d alu=%h sd=%h rd=%0d we=%b mem=%0d br=%b pc=%h",
                                     due.outcome.status, due.outcome.alu_result,
                                     due.outcome.store_data, due.outcome.dest_reg,
                                     due.outcome.wb_enable, due.outcome.mem_op,
                                     due.outcome.redirect, due.outcome.target_pc);
                            $display("  actual   st=%0d alu=%h sd=%h rd=%0d we=%b mem=%0d br=%b pc=%h",
                                     res.status, res.alu_result, res.store_data, res.dest_reg,
                                     res.wb_enable, res.mem_op, res.redirect, res.target_pc);
                        end
                    end
                end
            end

            if (stall_left > 0)
            begin
                res_stall  <= 1'b1;
                stall_left <= stall_left - 1;
            end
            else if (calm_out > 0)
            begin
                res_stall <= 1'b0;
                calm_out = calm_out - 1;
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                res_stall  <= 1'b1;
                stall_left <= pick_gap();
            end
            else
            begin
                res_stall <= 1'b0;
                if ($urandom_range(0, 199) == 0)
                    calm_out = $urandom_range(30, 120);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout at cycle %0d with %0d results outstanding", cycle_count,
                     outcomes_due.size());
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        build_directed();
        build_random();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // drain: everything sent and every result back
        while (inst_backlog.size() != 0 || inst_valid || outcomes_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (outcomes_due.size() != 0)
            error_count = error_count + outcomes_due.size();

        $display("checked %0d of %0d instructions (%0d directed, rest random over all opcodes)",
                 checked, issued, directed_cnt);
        $display("  %0d redirects, %0d writebacks, %0d loads/stores, %0d trap statuses, %0d errors",
                 redirects, writebacks, mem_accesses, traps, error_count);
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
